// ===== design/utf16_name_to_utf8_assert.svh =====
// Assertion macros shared by the checker of the name converter.
`ifndef UTF16_NAME_TO_UTF8_ASSERT_SVH
`define UTF16_NAME_TO_UTF8_ASSERT_SVH

// Clocked assertion, muted while reset is high.
`define UTN_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("utn assertion failed");

// Clocked assertion that also holds during reset.
`define UTN_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("utn assertion failed");

`endif

// ===== design/utn_pkg.sv =====
// Types and constants of the UTF-16 name to UTF-8 converter.
package utn_pkg;

   localparam int unsigned MAX_NAME_BYTES = 1024;

   localparam logic [15:0] NUL_UNIT    = 16'h0000;
   localparam logic [15:0] NUL_SUBST   = 16'h005e;
   localparam logic [15:0] SLASH_UNIT  = 16'h002f;
   localparam logic [15:0] SLASH_SUBST = 16'h003a;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_ILLEGAL   = 2'd1;
   localparam logic [1:0] ST_EXHAUSTED = 2'd2;
   localparam logic [1:0] ST_TARGET    = 2'd3;

   localparam logic CSR_BIG_ENDIAN = 1'b0;
   localparam logic CSR_OUT_LIMIT  = 1'b1;

   typedef struct packed {
      logic        big_endian;
      logic [10:0] out_limit;
   } utn_cfg_type;

   // Work for the back end: the bytes of one input word and an optional status.
   typedef struct packed {
      logic [3:0][7:0] bytes;
      logic [2:0]      nbytes;
      logic            has_status;
      logic [1:0]      status;
   } utn_job_type;

endpackage

// ===== design/utn_queue.sv =====
// Small FIFO of jobs between the front end and the back end.
module utn_queue #(
   parameter int DEPTH = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  utn_pkg::utn_job_type push_job,
   output logic                full,
   input  logic                pop,
   output logic                head_valid,
   output utn_pkg::utn_job_type head_job
);
   import utn_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   utn_job_type mem_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0] count_ff;
   logic          do_push, do_pop;

   assign full       = (count_ff == CW'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_job   = mem_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

// ===== design/utn_front.sv =====
// Front end: byte order, substitution, surrogate pairing, limit check, job build.
module utn_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [15:0]          req_code_unit,
   input  logic                 req_end_of_string,
   input  utn_pkg::utn_cfg_type cfg,
   input  logic                 queue_full,
   output logic                 push,
   output utn_pkg::utn_job_type push_job
);
   import utn_pkg::*;

   logic [9:0]  hs_ff, hs_in;
   logic        pend_ff, pend_in;
   logic [10:0] emitted_ff, emitted_in;
   logic        failed_ff, failed_in;
   logic [1:0]  code_ff, code_in;

   logic        accept;
   logic [15:0] u_sw, u;
   logic        is_high, is_low;
   logic        enc_go;
   logic [20:0] cp;
   logic [2:0]  n;
   logic [3:0][7:0] enc_bytes;
   logic [11:0] sum;
   logic [10:0] lim, room;
   utn_job_type job;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;

   always_comb begin
      u_sw = cfg.big_endian ? req_code_unit : {req_code_unit[7:0], req_code_unit[15:8]};
      if (u_sw == NUL_UNIT) begin
         u = NUL_SUBST;
      end else if (u_sw == SLASH_UNIT) begin
         u = SLASH_SUBST;
      end else begin
         u = u_sw;
      end
      is_high = (u[15:10] == 6'b110110);
      is_low  = (u[15:10] == 6'b110111);
   end

   // room = min(out_limit, max) - 1, floor at zero
   always_comb begin
      lim  = (cfg.out_limit > 11'(MAX_NAME_BYTES)) ? 11'(MAX_NAME_BYTES) : cfg.out_limit;
      room = (lim == '0) ? '0 : lim - 11'd1;
   end

   always_comb begin
      hs_in      = hs_ff;
      pend_in    = pend_ff;
      emitted_in = emitted_ff;
      failed_in  = failed_ff;
      code_in    = code_ff;
      enc_go     = 1'b0;
      cp         = {5'd0, u};
      job        = '0;

      if (!failed_ff) begin
         if (pend_ff) begin
            if (is_low) begin
               cp      = {(11'({1'b0, hs_ff}) + 11'd64), u[9:0]};
               enc_go  = 1'b1;
               pend_in = 1'b0;
               hs_in   = '0;
            end else begin
               failed_in = 1'b1;
               code_in   = ST_ILLEGAL;
               pend_in   = 1'b0;
               hs_in     = '0;
            end
         end else if (is_high) begin
            if (req_end_of_string) begin
               failed_in = 1'b1;
               code_in   = ST_EXHAUSTED;
            end else begin
               hs_in   = u[9:0];
               pend_in = 1'b1;
            end
         end else if (is_low) begin
            failed_in = 1'b1;
            code_in   = ST_ILLEGAL;
         end else begin
            enc_go = 1'b1;
         end
      end

      if (cp[20:7] == '0) begin
         n         = 3'd1;
         enc_bytes = {8'd0, 8'd0, 8'd0, cp[7:0]};
      end else if (cp[20:11] == '0) begin
         n         = 3'd2;
         enc_bytes = {8'd0, 8'd0, {2'b10, cp[5:0]}, {3'b110, cp[10:6]}};
      end else if (cp[20:16] == '0) begin
         n         = 3'd3;
         enc_bytes = {8'd0, {2'b10, cp[5:0]}, {2'b10, cp[11:6]}, {4'b1110, cp[15:12]}};
      end else begin
         n         = 3'd4;
         enc_bytes = {{2'b10, cp[5:0]}, {2'b10, cp[11:6]}, {2'b10, cp[17:12]},
                      {5'b11110, cp[20:18]}};
      end
      sum = {1'b0, emitted_ff} + 12'(n);

      if (enc_go) begin
         if (sum > {1'b0, room}) begin
            failed_in = 1'b1;
            code_in   = ST_TARGET;
            pend_in   = 1'b0;
            hs_in     = '0;
         end else begin
            emitted_in = sum[10:0];
            job.bytes  = enc_bytes;
            job.nbytes = n;
         end
      end

      if (req_end_of_string) begin
         job.has_status = 1'b1;
         job.status     = failed_in ? code_in : ST_OK;
         hs_in          = '0;
         pend_in        = 1'b0;
         emitted_in     = '0;
         failed_in      = 1'b0;
         code_in        = ST_OK;
      end
   end

   assign push     = accept && (job.has_status || (job.nbytes != '0));
   assign push_job = job;

   always_ff @(posedge clock) begin
      if (reset) begin
         hs_ff      <= '0;
         pend_ff    <= 1'b0;
         emitted_ff <= '0;
         failed_ff  <= 1'b0;
         code_ff    <= ST_OK;
      end else if (accept) begin
         hs_ff      <= hs_in;
         pend_ff    <= pend_in;
         emitted_ff <= emitted_in;
         failed_ff  <= failed_in;
         code_ff    <= code_in;
      end
   end

endmodule

// ===== design/utn_back.sv =====
// Back end: unrolls one job into its byte words and, at end of string, a status word, one per cycle while not stalled.
module utn_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 head_valid,
   input  utn_pkg::utn_job_type head_job,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [7:0]           rsp_out_byte,
   output logic                 rsp_byte_valid,
   output logic                 rsp_run_last,
   output logic                 rsp_string_done,
   output logic [1:0]           rsp_status
);
   import utn_pkg::*;

   logic [2:0] idx_ff;
   logic [2:0] total;
   logic       is_byte, last_word, load;
   logic       valid_ff;
   logic [7:0] byte_ff;
   logic       bvalid_ff, run_last_ff, done_ff;
   logic [1:0] status_ff;

   assign total     = head_job.nbytes + 3'(head_job.has_status);
   assign is_byte   = (idx_ff < head_job.nbytes);
   assign last_word = ((idx_ff + 3'd1) == total);
   assign load      = head_valid && (!valid_ff || rsp_ready);
   assign pop       = load && last_word;

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         if (load) begin
            idx_ff   <= last_word ? '0 : idx_ff + 3'd1;
            valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff     <= is_byte ? head_job.bytes[idx_ff[1:0]] : 8'd0;
         bvalid_ff   <= is_byte;
         run_last_ff <= last_word;
         done_ff     <= !is_byte;
         status_ff   <= is_byte ? ST_OK : head_job.status;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_out_byte    = byte_ff;
   assign rsp_byte_valid  = bvalid_ff;
   assign rsp_run_last    = run_last_ff;
   assign rsp_string_done = done_ff;
   assign rsp_status      = status_ff;

endmodule

// ===== design/utf16_name_to_utf8.sv =====
// The results of a code unit pass through the job queue and then the output register.
// Throughput: the front end takes one code unit per cycle while the job queue
// has room; the back end sends one result word per cycle while the receiver is
// ready, so a unit yields 0 to 5 words there (1-4 UTF-8 bytes, plus a status word on end of string).
// Reset (synchronous, active high) empties the queue and output register,
// clears the string state, and sets big_endian = 1, out_limit = 1024.
module utf16_name_to_utf8 #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   // code unit input
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [15:0] req_code_unit,
   input  logic        req_end_of_string,
   // result output
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_byte_valid,
   output logic        rsp_run_last,
   output logic        rsp_string_done,
   output logic [1:0]  rsp_status,
   // register writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [10:0] csr_data
);
   import utn_pkg::*;

   utn_cfg_type cfg_ff;
   logic        q_push, q_full, q_pop, q_head_valid;
   utn_job_type q_push_job, q_head_job;

   // Register writes are always taken; they must only arrive while idle, which the block does not enforce.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.big_endian <= 1'b1;
         cfg_ff.out_limit  <= 11'd1024;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_BIG_ENDIAN: cfg_ff.big_endian <= csr_data[0];
            CSR_OUT_LIMIT:  cfg_ff.out_limit  <= csr_data;
            default:        cfg_ff            <= cfg_ff;
         endcase
      end
   end

   // Front end: all per-string state lives here, updated once per word.
   utn_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_code_unit     (req_code_unit),
      .req_end_of_string (req_end_of_string),
      .cfg               (cfg_ff),
      .queue_full        (q_full),
      .push              (q_push),
      .push_job          (q_push_job)
   );

   // Jobs of up to five results wait here so a stalled output doesn't block input.
   utn_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_job   (q_push_job),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_head_valid),
      .head_job   (q_head_job)
   );

   // Back end: one result word per cycle into the output register while the output is not stalled.
   utn_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_valid      (q_head_valid),
      .head_job        (q_head_job),
      .pop             (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_byte_valid  (rsp_byte_valid),
      .rsp_run_last    (rsp_run_last),
      .rsp_string_done (rsp_string_done),
      .rsp_status      (rsp_status)
   );

endmodule

// ===== design/utn_checker.sv =====
// Port-level checker of the name converter, bound to the top level.
`include "utf16_name_to_utf8_assert.svh"

module utn_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_byte_valid,
   input logic       rsp_run_last,
   input logic       rsp_string_done,
   input logic [1:0] rsp_status
);

   // a stalled result word holds
   `UTN_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte) && $stable(rsp_status))

   // byte words carry no status
   `UTN_ASSERT(a_byte_word, clock, reset, rsp_valid && rsp_byte_valid |-> !rsp_string_done && (rsp_status == 2'd0))

   // the status word closes its run and carries no byte
   `UTN_ASSERT(a_status_word, clock, reset, rsp_valid && rsp_string_done |-> rsp_run_last && !rsp_byte_valid && (rsp_out_byte == 8'd0))

   // every word without a byte is the status word
   `UTN_ASSERT_ALWAYS(a_no_empty_word, clock, !reset && rsp_valid && !rsp_byte_valid |-> rsp_string_done)

endmodule

bind utf16_name_to_utf8 utn_checker u_utn_checker (.*);

// ===== bench/tb.sv =====
// Testbench of utf16_name_to_utf8: converts random and directed names, checks every word.
`timescale 1ns / 1ps

module tb;
   import utn_pkg::*;

   // No handshake for this many cycles means the block has hung.
   localparam int WATCHDOG_LIMIT = 3000;
   // Quiet units (held high surrogates, units after an error) give no word,
   // so give the pipeline time to empty before a register write or the end.
   localparam int DRAIN_CYCLES   = 16;
   // Items per random block, between two register settings.
   localparam int BLOCK_ITEMS    = 22;

   // One result word as it leaves the block.
   typedef struct {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       run_last;
      logic       string_done;
      logic [1:0] status;
   } utf8_word_type;

   // Predicts the words of every accepted code unit and checks the ones that come out.
   class name_scoreboard;
      bit         big_endian = 1'b1;
      bit [10:0]  out_limit  = 11'd1024;
      bit [9:0]   held_high;
      bit         held;
      bit [10:0]  emitted;
      bit         failed;
      logic [1:0] fail_code = ST_OK;
      utf8_word_type expected_words[$];
      utf8_word_type batch[$];
      int         errors;

      function void clear_string();
         held_high = '0;
         held      = 1'b0;
         emitted   = '0;
         failed    = 1'b0;
         fail_code = ST_OK;
      endfunction

      function void set_reg(logic idx, logic [10:0] data);
         if (idx == CSR_BIG_ENDIAN) begin
            big_endian = data[0];
         end else begin
            out_limit = data;
         end
      endfunction

      function void flag(logic [1:0] code);
         failed    = 1'b1;
         fail_code = code;
         held      = 1'b0;
         held_high = '0;
      endfunction

      // Usable bytes: one slot is kept for the terminator.
      function int unsigned room();
         int unsigned lim;
         lim = (out_limit > MAX_NAME_BYTES) ? MAX_NAME_BYTES : out_limit;
         return (lim == 0) ? 0 : lim - 1;
      endfunction

      function void add_word(logic [7:0] b, logic valid, logic done, logic [1:0] st);
         utf8_word_type w;
         w.out_byte    = b;
         w.byte_valid  = valid;
         w.run_last    = 1'b0;
         w.string_done = done;
         w.status      = st;
         batch.push_back(w);
      endfunction

      // All bytes of a character go out, or none and target_exhausted.
      function void emit_char(int unsigned cp);
         logic [7:0] b [4];
         int unsigned n;
         if (cp < 'h80) begin
            n = 1;
            b[0] = cp[7:0];
         end else if (cp < 'h800) begin
            n = 2;
            b[0] = 8'hc0 | cp[10:6];
            b[1] = 8'h80 | cp[5:0];
         end else if (cp < 'h10000) begin
            n = 3;
            b[0] = 8'he0 | cp[15:12];
            b[1] = 8'h80 | cp[11:6];
            b[2] = 8'h80 | cp[5:0];
         end else begin
            n = 4;
            b[0] = 8'hf0 | cp[20:18];
            b[1] = 8'h80 | cp[17:12];
            b[2] = 8'h80 | cp[11:6];
            b[3] = 8'h80 | cp[5:0];
         end
         if (int'(emitted) + n > room()) begin
            flag(ST_TARGET);
         end else begin
            for (int i = 0; i < n; i++) add_word(b[i], 1'b1, 1'b0, ST_OK);
            emitted = 11'(emitted + n);
         end
      endfunction

      function void note_unit(logic [15:0] raw, logic eos);
         logic [15:0] u;
         bit          is_high;
         bit          is_low;
         batch.delete();
         u = big_endian ? raw : {raw[7:0], raw[15:8]};
         if (u == NUL_UNIT) u = NUL_SUBST;
         else if (u == SLASH_UNIT) u = SLASH_SUBST;
         is_high = (u >= 16'hd800) && (u <= 16'hdbff);
         is_low  = (u >= 16'hdc00) && (u <= 16'hdfff);
         if (!failed) begin
            if (held) begin
               if (is_low) begin
                  held = 1'b0;
                  emit_char(32'h10000 + (int'(held_high) << 10) + (u - 16'hdc00));
                  held_high = '0;
               end else begin
                  flag(ST_ILLEGAL);
               end
            end else if (is_high) begin
               if (eos) begin
                  flag(ST_EXHAUSTED);
               end else begin
                  held_high = u[9:0];
                  held      = 1'b1;
               end
            end else if (is_low) begin
               flag(ST_ILLEGAL);
            end else begin
               emit_char({16'd0, u});
            end
         end
         if (eos) begin
            add_word(8'h00, 1'b0, 1'b1, failed ? fail_code : ST_OK);
            clear_string();
         end
         if (batch.size() > 0) batch[batch.size() - 1].run_last = 1'b1;
         foreach (batch[i]) expected_words.push_back(batch[i]);
      endfunction

      function void compare_field(string field, logic [7:0] exp_v, logic [7:0] got_v);
         if (got_v !== exp_v) begin
            $error("%s: expected %0h, got %0h", field, exp_v, got_v);
            errors++;
         end
      endfunction

      function void check_word(utf8_word_type got);
         utf8_word_type exp_w;
         if (expected_words.size() == 0) begin
            $error("word with nothing expected: out_byte %0h byte_valid %0b status %0d",
                   got.out_byte, got.byte_valid, got.status);
            errors++;
            return;
         end
         exp_w = expected_words.pop_front();
         compare_field("out_byte", exp_w.out_byte, got.out_byte);
         compare_field("byte_valid", exp_w.byte_valid, got.byte_valid);
         compare_field("run_last", exp_w.run_last, got.run_last);
         compare_field("string_done", exp_w.string_done, got.string_done);
         compare_field("status", exp_w.status, got.status);
      endfunction

      function int pending();
         return expected_words.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [15:0] req_code_unit = '0;
   logic        req_end_of_string = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic        rsp_byte_valid;
   logic        rsp_run_last;
   logic        rsp_string_done;
   logic [1:0]  rsp_status;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = CSR_BIG_ENDIAN;
   logic [10:0] csr_data = '0;

   name_scoreboard sb = new();
   logic [15:0]    name_units[$];   // raw code units of the name being sent
   int unsigned    items_sent;
   int             req_idle_pct = 25;
   int             rsp_stall_pct = 85;
   int             idle_cycles;

   utf16_name_to_utf8 u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_code_unit     (req_code_unit),
      .req_end_of_string (req_end_of_string),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_byte_valid    (rsp_byte_valid),
      .rsp_run_last      (rsp_run_last),
      .rsp_string_done   (rsp_string_done),
      .rsp_status        (rsp_status),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Receiver back-pressure: a fresh draw each cycle, applied at the falling edge.
   always @(negedge clock) begin
      rsp_ready = ($urandom_range(99) >= rsp_stall_pct);
   end

   // Every accepted word goes to the scoreboard, sampled at the rising edge.
   always @(posedge clock) begin : word_monitor
      utf8_word_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got.out_byte    = rsp_out_byte;
         got.byte_valid  = rsp_byte_valid;
         got.run_last    = rsp_run_last;
         got.string_done = rsp_string_done;
         got.status      = rsp_status;
         sb.check_word(got);
      end
   end

   // Watchdog: any handshake on any channel counts as progress.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Logical unit to the byte order the block currently expects.
   function logic [15:0] raw_of(logic [15:0] u);
      return sb.big_endian ? u : {u[7:0], u[15:8]};
   endfunction

   // Mostly well-formed names with random content, some noise mixed in.
   function void build_random_name(int len);
      int kind;
      while (name_units.size() < len) begin
         kind = $urandom_range(99);
         if (kind < 30) begin
            if ($urandom_range(9) == 0) begin
               name_units.push_back(raw_of($urandom_range(1) ? NUL_UNIT : SLASH_UNIT));
            end else begin
               name_units.push_back(raw_of(16'($urandom_range(16'h7f))));
            end
         end else if (kind < 50) begin
            name_units.push_back(raw_of(16'($urandom_range(16'h7ff, 16'h80))));
         end else if (kind < 70) begin
            if ($urandom_range(1)) begin
               name_units.push_back(raw_of(16'($urandom_range(16'hd7ff, 16'h800))));
            end else begin
               name_units.push_back(raw_of(16'($urandom_range(16'hffff, 16'he000))));
            end
         end else if (kind < 88) begin
            // surrogate pair; at the end of the name it may run one unit past the length
            name_units.push_back(raw_of(16'($urandom_range(16'hdbff, 16'hd800))));
            name_units.push_back(raw_of(16'($urandom_range(16'hdfff, 16'hdc00))));
         end else if (kind < 93) begin
            name_units.push_back(raw_of(16'($urandom_range(16'hdfff, 16'hdc00))));
         end else if (kind < 96) begin
            name_units.push_back(raw_of(16'($urandom_range(16'hdbff, 16'hd800))));
         end else begin
            name_units.push_back(16'($urandom_range(16'hffff)));
         end
      end
   endfunction

   // Small limits come up often so target_exhausted does too.
   function logic [10:0] pick_limit();
      case ($urandom_range(5))
         0: return 11'($urandom_range(5));
         1: return 11'($urandom_range(20, 6));
         2: return 11'd1024;
         3: return 11'd2047;
         4: return 11'($urandom_range(2047));
         default: return 11'd1023;
      endcase
   endfunction

   // Called at a falling edge; returns at a falling edge.
   task automatic write_reg(logic idx, logic [10:0] data);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = data;
      do @(posedge clock); while (!csr_ready);
      sb.set_reg(idx, data);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Sends name_units, end_of_string on the last one. Valid stays high between
   // back-to-back words and drops only on a sender idle cycle.
   task automatic send_string();
      foreach (name_units[i]) begin
         while ($urandom_range(99) < req_idle_pct) begin
            req_valid = 1'b0;
            @(negedge clock);
         end
         req_valid         = 1'b1;
         req_code_unit     = name_units[i];
         req_end_of_string = (i == name_units.size() - 1);
         do @(posedge clock); while (!req_ready);
         sb.note_unit(req_code_unit, req_end_of_string);
         items_sent++;
         @(negedge clock);
      end
      name_units.delete();
   endtask

   // Idle point: all expected words seen and the pipeline given time to empty.
   task automatic settle();
      req_valid = 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   initial begin : stimulus
      int unsigned block_start;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: reset settings written back explicitly.
      write_reg(CSR_BIG_ENDIAN, 11'd1);
      write_reg(CSR_OUT_LIMIT, 11'd1024);
      // NUL and slash substitution, every UTF-8 length boundary, both ends
      // of the surrogate ranges paired up.
      name_units = '{16'h0000, 16'h002f, 16'h007f, 16'h0080, 16'h07ff, 16'h0800,
                     16'hffff, 16'hd800, 16'hdc00, 16'hdbff, 16'hdfff};
      send_string();
      // lone low surrogate; the unit after it is ignored
      name_units = '{16'hdc00, 16'h0041};
      send_string();
      // high surrogate followed by a plain unit, then an ignored unit
      name_units = '{16'hd800, 16'h0041, 16'hd800};
      send_string();
      // high surrogate as the last unit
      name_units = '{16'hdbff};
      send_string();

      // Little endian with a 3-byte buffer: slash fits, the 3-byte char does not.
      settle();
      write_reg(CSR_BIG_ENDIAN, 11'd0);
      write_reg(CSR_OUT_LIMIT, 11'd3);
      name_units = '{16'h2f00, 16'h0008, 16'h4100};
      send_string();
      // zero-size buffer: the first character already overflows
      settle();
      write_reg(CSR_OUT_LIMIT, 11'd0);
      name_units = '{16'h4100};
      send_string();

      // Random: three idling profiles, three register settings each.
      for (int ph = 0; ph < 3; ph++) begin
         case (ph)
            0: begin
               req_idle_pct  = 25;
               rsp_stall_pct = 85;
            end
            1: begin
               req_idle_pct  = 85;
               rsp_stall_pct = 25;
            end
            default: begin
               req_idle_pct  = 0;
               rsp_stall_pct = 0;
            end
         endcase
         for (int blk = 0; blk < 3; blk++) begin
            settle();
            write_reg(CSR_BIG_ENDIAN, 11'($urandom_range(1)));
            write_reg(CSR_OUT_LIMIT, pick_limit());
            block_start = items_sent;
            while (items_sent - block_start < BLOCK_ITEMS) begin
               build_random_name(int'($urandom_range(10, 1)));
               send_string();
            end
         end
      end

      settle();
      if (sb.pending() != 0) begin
         $error("%0d expected words never arrived", sb.pending());
         sb.errors++;
      end
      if (sb.errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+design
design/utn_pkg.sv
design/utn_queue.sv
design/utn_front.sv
design/utn_back.sv
design/utf16_name_to_utf8.sv
design/utn_checker.sv
bench/tb.sv
